[rtl/rdc_pkg.sv]
// Shared constants and types of the radix digit converter.
package rdc_pkg;

  localparam int unsigned RDC_VALUE_WIDTH = 64;
  localparam int unsigned RDC_MAX_RADIX   = 16;

  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ALPHA_W    = 128;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

  // Characters that may not appear in the alphabet.
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX      = 2'd0,
    REG_ALPHA_LOW  = 2'd1,
    REG_ALPHA_HIGH = 2'd2
  } rdc_reg_e;

endpackage

[rtl/radix_digit_converter.sv]
// Top level of the radix digit converter: alphabet check, byte-serial divider, digit stack.
//
//  channel   direction  handshake                       payload
//  --------  ---------  ------------------------------  --------------------------------
//  request   in         start_i, busy_o                 value_i
//  config    in         cfg_valid_i, cfg_ready_o        cfg_index_i, cfg_data_i
//  result    out        out_valid_o (one-cycle strobe)  digit_char_o, last_o, error_o
//
//  A request is taken when start_i is high and busy_o low. The alphabet check steps through
//  the radix characters (stopping early on an error), the shared divider runs over each
//  significant byte of the running quotient (at most 8) for each digit, then the digits pop.
//  Reset sets radix 16 and a zero alphabet, so every request errors until it is written.
//  The receiver cannot stall; cfg_ready_o stays low while a request is in flight.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = RDC_VALUE_WIDTH,
  parameter int unsigned MAX_RADIX   = RDC_MAX_RADIX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic                  last_o,
  output logic                  error_o
);

  // Byte layout of the working quotient.
  localparam int unsigned NB      = (VALUE_WIDTH + 7) / 8;
  localparam int unsigned WW      = NB * 8;
  localparam int unsigned IDX_W   = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned NBC_W   = $clog2(NB + 1);
  // A digit, and the running remainder, stay below the radix.
  localparam int unsigned DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  // Binary gives the most digits: one per value bit.
  localparam int unsigned DEPTH   = VALUE_WIDTH;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  // Look up the alphabet character of a digit.
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
                                                   input logic [DIGIT_W-1:0] dig);
    logic [3:0] ix;
    ix = 4'(dig);
    return alpha[ix*8 +: 8];
  endfunction

  // Divide {rem, b} by r, one restoring step per bit of b; returns {quotient, remainder}.
  function automatic logic [8+DIGIT_W-1:0] div_byte(input logic [DIGIT_W-1:0] rem,
                                                    input logic [7:0]         b,
                                                    input logic [RADIX_W-1:0] r);
    logic [DIGIT_W:0]   t;
    logic [RADIX_W-1:0] te;
    logic [DIGIT_W-1:0] p;
    logic [7:0]         q;
    p = rem;
    q = '0;
    for (int k = 7; k >= 0; k--) begin
      t  = {p, b[k]};
      te = RADIX_W'(t);
      if (te >= r) begin
        q[k] = 1'b1;
        p    = DIGIT_W'(te - r);
      end else begin
        p    = t[DIGIT_W-1:0];
      end
    end
    return {q, p};
  endfunction

  // Configuration registers.
  logic [RADIX_W-1:0]    radix_q;
  logic [CFG_DATA_W-1:0] alpha_low_q;
  logic [CFG_DATA_W-1:0] alpha_high_q;
  logic [ALPHA_W-1:0]    alpha;

  // Control state.
  state_e             state_q, state_d;
  logic [NBC_W-1:0]   nb_q, nb_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [DIGIT_W-1:0] chk_q, chk_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  // Payload.
  logic [7:0]         w_q [NB];
  logic [7:0]         w_d [NB];
  logic [DIGIT_W-1:0] stk_q [DEPTH];
  logic [DIGIT_W-1:0] stk_d [DEPTH];
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic               err_q, err_d;

  // Helpers.
  logic [WW-1:0]       value_ext;
  logic [NBC_W-1:0]    nb_init;
  logic                radix_ok;
  logic [CHAR_W-1:0]   chk_char;
  logic                chk_bad;
  logic                chk_last;
  logic [8+DIGIT_W-1:0] div_res;
  logic [7:0]          quot_byte;
  logic [DIGIT_W-1:0]  div_rem;
  logic [IDX_W-1:0]    top_idx;
  logic                top_zero;
  logic [NBC_W-1:0]    nb_next;

  assign alpha       = {alpha_high_q, alpha_low_q};
  // Hold configuration writes off while a request is in flight.
  assign cfg_ready_o = (state_q == ST_IDLE);

  // Take configuration writes; drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q      <= RADIX_RESET;
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RADIX:      radix_q      <= cfg_data_i[RADIX_W-1:0];
        REG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i;
        REG_ALPHA_HIGH: alpha_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero-extend the used value bits and count its significant bytes; zero counts as one.
  always_comb begin
    value_ext = WW'(value_i[VALUE_WIDTH-1:0]);
    nb_init   = NBC_W'(1);
    for (int k = 0; k < NB; k++) begin
      if (value_ext[k*8 +: 8] != 8'h00) begin
        nb_init = NBC_W'(k + 1);
      end
    end
  end

  // Alphabet check for one character against every later character in use.
  always_comb begin
    radix_ok = radix_q inside {[RADIX_W'(2):RADIX_W'(MAX_RADIX)]};
    chk_char = alpha_char(alpha, chk_q);
    chk_bad  = (chk_char == CHAR_PLUS) || (chk_char == CHAR_MINUS) || (chk_char == CHAR_NUL);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((DIGIT_W'(j) > chk_q) && (RADIX_W'(j) < radix_q) &&
          (alpha_char(alpha, DIGIT_W'(j)) == chk_char)) begin
        chk_bad = 1'b1;
      end
    end
    chk_last = (RADIX_W'(chk_q) + RADIX_W'(1)) == radix_q;
  end

  // Shared divider step on the current byte.
  always_comb begin
    div_res   = div_byte(rem_q, w_q[idx_q], radix_q);
    quot_byte = div_res[8+DIGIT_W-1:DIGIT_W];
    div_rem   = div_res[DIGIT_W-1:0];
    top_idx   = IDX_W'(nb_q - NBC_W'(1));
    // On a single byte the top byte is the one just divided.
    top_zero  = (nb_q == NBC_W'(1)) ? (quot_byte == 8'h00) : (w_q[top_idx] == 8'h00);
    nb_next   = top_zero ? (nb_q - NBC_W'(1)) : nb_q;
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    nb_d        = nb_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    chk_d       = chk_q;
    cnt_d       = cnt_q;
    out_valid_d = 1'b0;
    w_d         = w_q;
    stk_d       = stk_q;
    char_d      = char_q;
    last_d      = last_q;
    err_d       = err_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < NB; k++) begin
            w_d[k] = value_ext[k*8 +: 8];
          end
          nb_d    = nb_init;
          idx_d   = IDX_W'(nb_init - NBC_W'(1));
          rem_d   = '0;
          chk_d   = '0;
          cnt_d   = '0;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (!radix_ok || chk_bad) begin
          // Report the bad alphabet as the only result.
          out_valid_d = 1'b1;
          char_d      = CHAR_NUL;
          last_d      = 1'b1;
          err_d       = 1'b1;
          state_d     = ST_IDLE;
        end else if (chk_last) begin
          state_d = ST_DIVIDE;
        end else begin
          chk_d = chk_q + DIGIT_W'(1);
        end
      end

      ST_DIVIDE: begin
        w_d[idx_q] = quot_byte;
        if (idx_q == '0) begin
          // Push the finished digit; the stack pops most significant first.
          stk_d[0] = div_rem;
          for (int k = 1; k < DEPTH; k++) begin
            stk_d[k] = stk_q[k-1];
          end
          cnt_d = cnt_q + CNT_W'(1);
          rem_d = '0;
          if ((nb_q == NBC_W'(1)) && (quot_byte == 8'h00)) begin
            state_d = ST_EMIT;
          end else begin
            nb_d  = nb_next;
            idx_d = IDX_W'(nb_next - NBC_W'(1));
          end
        end else begin
          idx_d = idx_q - IDX_W'(1);
          rem_d = div_rem;
        end
      end

      ST_EMIT: begin
        out_valid_d = 1'b1;
        char_d      = alpha_char(alpha, stk_q[0]);
        last_d      = (cnt_q == CNT_W'(1));
        err_d       = 1'b0;
        for (int k = 0; k < DEPTH - 1; k++) begin
          stk_d[k] = stk_q[k+1];
        end
        stk_d[DEPTH-1] = '0;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nb_q        <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      chk_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_q        <= nb_d;
      idx_q       <= idx_d;
      rem_q       <= rem_d;
      chk_q       <= chk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
      err_q       <= err_d;
    end
  end

  // Payload: quotient bytes and digit stack.
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    stk_q  <= stk_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;
  assign error_o      = err_q;

  // An error result closes its run.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> last_o)
    else $error("error result without last");

  // Digits of one run follow back to back.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o)
    else $error("gap inside a digit run");

  // An accepted request makes the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // The digit stack is empty whenever the block is idle.
  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (cnt_q == '0))
    else $error("digits left over while idle");

  // The divider works inside the significant bytes.
  a_divide_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> ((nb_q != '0) && (NBC_W'(idx_q) < nb_q)))
    else $error("byte index outside the quotient");

endmodule

[verif/radix_digit_converter_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the radix digit converter: directed rows, then random phases.
module radix_digit_converter_tb;
  import rdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Longest conversion (64 binary digits of a full value) plus headroom.
  localparam int unsigned SETTLE_CYCLES = 400;
  // Register index outside the map: a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - RDC_VALUE_WIDTH);
  // Plain hexadecimal alphabet "0123456789abcdef", character 0 in the low byte.
  localparam logic [63:0] HEX_LOW  = 64'h3736353433323130;
  localparam logic [63:0] HEX_HIGH = 64'h6665646362613938;

  typedef enum logic [0:0] {
    ROW_WRITE,
    ROW_CONVERT
  } row_kind_e;

  // How a converted request is checked: by the predictor, against typed text, or as an error.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TEXT,
    CHK_ERROR
  } check_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [VALUE_W-1:0]     v;
    check_e                 chk;
    logic [8*20-1:0]        txt;
  } stim_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
    logic              err;
  } digit_rec_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [VALUE_W-1:0]    value_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  out_valid_o;
  logic [CHAR_W-1:0]     digit_char_o;
  logic                  last_o;
  logic                  error_o;

  // Predictor copy of the register file.
  logic [RADIX_W-1:0] pred_radix = RADIX_RESET;
  logic [ALPHA_W-1:0] pred_alpha = '0;

  digit_rec_t  pending_chars[$];
  stim_row_t   stim_rows[$];
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;

  radix_digit_converter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .error_o      (error_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Give up on a hung block: a correct run finishes far below this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Compare every strobed character with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    digit_rec_t want;
    if (rst_ni && out_valid_o) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected result: digit_char %h, last %b, error %b",
               digit_char_o, last_o, error_o);
        bad_count++;
      end else begin
        want = pending_chars.pop_front();
        if (digit_char_o !== want.ch) begin
          $error("digit_char: expected %h, got %h", want.ch, digit_char_o);
          bad_count++;
        end
        if (last_o !== want.is_last) begin
          $error("last: expected %b, got %b", want.is_last, last_o);
          bad_count++;
        end
        if (error_o !== want.err) begin
          $error("error: expected %b, got %b", want.err, error_o);
          bad_count++;
        end
      end
    end
  end

  function automatic void push_digit(logic [CHAR_W-1:0] ch, logic is_last, logic err);
    digit_rec_t rec;
    rec.ch      = ch;
    rec.is_last = is_last;
    rec.err     = err;
    pending_chars.push_back(rec);
  endfunction

  // Work out the characters that one request yields under the current registers.
  function automatic void predict_digits(logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] base;
    logic [CHAR_W-1:0]  c;
    int                 digs[64];
    int                 n;
    bit                 usable;
    v      = raw & VALUE_MASK;
    base   = VALUE_W'(pred_radix);
    usable = (pred_radix >= 2) && (pred_radix <= RDC_MAX_RADIX);
    // Only the first radix characters count: none may be a sign or a zero byte, and each must be unique.
    for (int i = 0; i < 16; i++) begin
      if (usable && i < pred_radix) begin
        c = pred_alpha[8*i +: 8];
        if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_NUL)
          usable = 1'b0;
        for (int j = i + 1; j < 16; j++)
          if (j < pred_radix && pred_alpha[8*j +: 8] == c)
            usable = 1'b0;
      end
    end
    if (!usable) begin
      push_digit(CHAR_NUL, 1'b1, 1'b1);
      return;
    end
    n = 0;
    if (v == 0) begin
      digs[0] = 0;
      n = 1;
    end
    while (v != 0) begin
      digs[n] = int'(v % base);
      v       = v / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--)
      push_digit(pred_alpha[8*digs[k] +: 8], k == 0, 1'b0);
  endfunction

  function automatic void put_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    stim_rows.push_back(row);
  endfunction

  function automatic void put_conv(logic [VALUE_W-1:0] v, check_e chk, logic [8*20-1:0] txt);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CONVERT;
    row.v    = v;
    row.chk  = chk;
    row.txt  = txt;
    stim_rows.push_back(row);
  endfunction

  // Sixteen distinct characters, none of them a sign or a zero byte.
  function automatic logic [ALPHA_W-1:0] random_alphabet();
    logic [ALPHA_W-1:0] alpha;
    bit                 used[256];
    int unsigned        c;
    foreach (used[i]) used[i] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      do c = $urandom_range(1, 255);
      while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
      used[c]          = 1'b1;
      alpha[8*i +: 8] = CHAR_W'(c);
    end
    return alpha;
  endfunction

  // Mix wide, narrow, tiny, radix-power, single-bit and low all-ones values.
  function automatic logic [VALUE_W-1:0] pick_value(logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] pw;
    logic [VALUE_W-1:0] base;
    base = (r < 2) ? VALUE_W'(2) : VALUE_W'(r);
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom} >> $urandom_range(0, 63);
      1: return VALUE_W'($urandom_range(0, 300));
      2: begin
        pw = 1;
        repeat ($urandom_range(1, 64))
          if (pw <= {VALUE_W{1'b1}} / base) pw = pw * base;
        return pw - VALUE_W'($urandom_range(0, 1));
      end
      3: return VALUE_W'(1) << $urandom_range(0, 63);
      4: return {VALUE_W{1'b1}} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Drop the request line and hold until every expected character is in and the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_chars.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RADIX:      pred_radix = data[RADIX_W-1:0];
      REG_ALPHA_LOW:  pred_alpha[63:0] = data;
      REG_ALPHA_HIGH: pred_alpha[127:64] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= {$urandom, $urandom};
  endtask

  // Offer one request after a random gap; record its expectation once it is taken.
  task automatic send_value(input logic [VALUE_W-1:0] v, input check_e chk,
                            input logic [8*20-1:0] txt);
    int n;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      value_i <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (chk)
      CHK_MODEL: predict_digits(v);
      CHK_ERROR: push_digit(CHAR_NUL, 1'b1, 1'b1);
      default: begin
        // Typed text is right-aligned; leading zero bytes are padding.
        n = 0;
        while (n < 20 && txt[8*n +: 8] != 0) n++;
        for (int k = n - 1; k >= 0; k--)
          push_digit(txt[8*k +: 8], k == 0, 1'b0);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [4:0]         r;
    logic [ALPHA_W-1:0] alpha;
    logic [CFG_DATA_W-1:0] rdata;
    int unsigned        pos;
    int unsigned        other;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_RADIX;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The alphabet is all zero bytes after reset, so expect errors first.
    put_conv(64'd0, CHK_ERROR, '0);
    put_conv({64{1'b1}}, CHK_ERROR, '0);
    // Low half alone is not enough at radix 16: characters 8 to 15 are still zero bytes.
    put_write(REG_ALPHA_LOW, HEX_LOW);
    put_conv(64'd5, CHK_ERROR, '0);
    put_write(REG_ALPHA_HIGH, HEX_HIGH);
    put_conv(64'd0, CHK_TEXT, "0");
    put_conv({64{1'b1}}, CHK_TEXT, "ffffffffffffffff");
    put_conv(64'h8000000000000000, CHK_TEXT, "8000000000000000");
    put_conv(64'h0123456789abcdef, CHK_TEXT, "123456789abcdef");
    // Only the low five bits of the radix data count: this write selects base ten.
    put_write(REG_RADIX, 64'hFFFFFFFFFFFFFFEA);
    put_conv({64{1'b1}}, CHK_TEXT, "18446744073709551615");
    put_conv(64'd1000, CHK_MODEL, '0);
    put_write(REG_RADIX, 64'd2);
    put_conv({64{1'b1}}, CHK_MODEL, '0);
    put_conv(64'd1, CHK_TEXT, "1");
    put_conv(64'd0, CHK_TEXT, "0");
    // A write to an unmapped index is dropped; base two must survive it.
    put_write(REG_UNUSED, {64{1'b1}});
    put_conv(64'd6, CHK_MODEL, '0);
    // Radix outside two to sixteen counts as an invalid alphabet.
    put_write(REG_RADIX, 64'd1);
    put_conv(64'd7, CHK_ERROR, '0);
    put_write(REG_RADIX, 64'd17);
    put_conv(64'd7, CHK_ERROR, '0);
    put_write(REG_RADIX, 64'd0);
    put_conv(64'd7, CHK_ERROR, '0);
    put_write(REG_RADIX, 64'd31);
    put_conv(64'd7, CHK_ERROR, '0);
    // Plus sign, minus sign and a repeated character in the alphabet.
    put_write(REG_RADIX, 64'd16);
    put_write(REG_ALPHA_LOW, 64'h373635342B323130);
    put_conv({64{1'b1}}, CHK_ERROR, '0);
    put_write(REG_ALPHA_LOW, 64'h373635343332312D);
    put_conv({64{1'b1}}, CHK_ERROR, '0);
    put_write(REG_ALPHA_LOW, HEX_LOW);
    put_write(REG_ALPHA_HIGH, 64'h3065646362613938);
    put_conv({64{1'b1}}, CHK_ERROR, '0);
    // The repeat sits in character 15, which base fifteen never looks at.
    put_write(REG_RADIX, 64'd15);
    put_conv({64{1'b1}}, CHK_MODEL, '0);
    // Zero bytes beyond the radix are ignored too.
    put_write(REG_RADIX, 64'd8);
    put_write(REG_ALPHA_HIGH, 64'd0);
    put_conv({64{1'b1}}, CHK_MODEL, '0);

    gap_pct = 8;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE)
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      else
        send_value(stim_rows[i].v, stim_rows[i].chk, stim_rows[i].txt);
    end

    // Random phases: fresh radix and alphabet each time, idling pattern rotated.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: r = 5'd2;
        1: r = 5'd16;
        2: r = 5'd10;
        3: r = 5'd8;
        6: r = 5'($urandom_range(0, 31));
        default: r = 5'($urandom_range(2, 16));
      endcase
      alpha = random_alphabet();
      // Break one phase's alphabet so that error runs also appear amid random traffic.
      if (p == 5) begin
        pos = $urandom_range(0, r - 1);
        case ($urandom_range(0, 3))
          0: alpha[8*pos +: 8] = CHAR_PLUS;
          1: alpha[8*pos +: 8] = CHAR_MINUS;
          2: alpha[8*pos +: 8] = CHAR_NUL;
          default: begin
            other = (pos + 1 + $urandom_range(0, r - 2)) % r;
            alpha[8*pos +: 8] = alpha[8*other +: 8];
          end
        endcase
      end
      rdata = {$urandom, $urandom};
      rdata[RADIX_W-1:0] = r;
      write_reg(REG_RADIX, rdata);
      write_reg(REG_ALPHA_LOW, alpha[63:0]);
      write_reg(REG_ALPHA_HIGH, alpha[127:64]);

      case (p % 3)
        0: gap_pct = 0;
        1: gap_pct = 74;
        default: gap_pct = 8;
      endcase
      for (int n = 0; n < 36; n++) begin
        // Now and then hold the next request until the block has drained.
        if ($urandom_range(0, 19) == 0)
          wait_idle();
        send_value(pick_value(r), CHK_MODEL, '0);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bad_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
